### hw/rtl/dscq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dscq_pkg;
   localparam int DEPTH = 16;
   localparam int TIME_BITS = 48;
   localparam int IDX_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam int CB_BITS = 8;
   localparam int OBJ_BITS = 16;
   localparam int MC_BITS = 6;
   localparam int FIFO_DEPTH = 2;

   typedef enum logic [3:0] {
      KIND_INSERT    = 4'd0,
      KIND_ERASE_CB  = 4'd1,
      KIND_ERASE_PR  = 4'd2,
      KIND_UPDATE    = 4'd3,
      KIND_INVOKE    = 4'd4,
      KIND_TIME_LEFT = 4'd5,
      KIND_COUNT_CB  = 4'd6,
      KIND_COUNT_PR  = 4'd7,
      KIND_CLEAR     = 4'd8
   } kind_type;

   // classified command between front and back
   typedef struct packed {
      logic                 do_insert;
      logic                 do_erase;
      logic                 erase_one;
      logic                 do_count;
      logic                 flag_only;
      logic                 do_invoke;
      logic                 do_tleft;
      logic                 do_clear;
      logic [CB_BITS-1:0]   cb;
      logic [OBJ_BITS-1:0]  obj;
      logic                 match_obj;
      logic [TIME_BITS-1:0] deadline;
      logic [TIME_BITS-1:0] now_time;
   } cmd_type;

   typedef struct packed {
      logic                       fired;
      logic [CB_BITS-1:0]         cb;
      logic [OBJ_BITS-1:0]        obj;
      logic [MC_BITS-1:0]         cnt;
      logic signed [TIME_BITS-1:0] tleft;
      logic                       full_err;
      logic                       last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REMOVE,
      ST_INSERT,
      ST_INVOKE
   } state_type;
endpackage
`default_nettype wire

### hw/rtl/dscq_front.sv
`timescale 1ns / 1ps
`default_nettype none
module dscq_front import dscq_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   output logic                      full,
   input  wire logic [3:0]           kind,
   input  wire logic [CB_BITS-1:0]   cb,
   input  wire logic [OBJ_BITS-1:0]  obj,
   input  wire logic [TIME_BITS-1:0] deadline,
   input  wire logic [TIME_BITS-1:0] now_time,
   output logic                      cmd_valid,
   output cmd_type                   cmd,
   input  wire logic                 cmd_take
);
   localparam int PB = $clog2(FIFO_DEPTH);
   cmd_type         mem_ff [FIFO_DEPTH];
   logic [PB-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [PB:0]     n_ff, n_in;
   cmd_type         c;
   logic            wr, rd;

   always_comb begin
      c = '0;
      c.cb = cb;
      c.obj = obj;
      c.deadline = deadline;
      c.now_time = now_time;
      unique case (kind)
         KIND_INSERT:    c.do_insert = 1'b1;
         KIND_ERASE_CB:  c.do_erase = 1'b1;
         KIND_ERASE_PR: begin
            c.do_erase = 1'b1; c.match_obj = 1'b1; c.flag_only = 1'b1;
         end
         KIND_UPDATE: begin
            c.do_erase = 1'b1; c.erase_one = 1'b1; c.match_obj = 1'b1;
            c.do_insert = 1'b1;
         end
         KIND_INVOKE:    c.do_invoke = 1'b1;
         KIND_TIME_LEFT: c.do_tleft = 1'b1;
         KIND_COUNT_CB:  c.do_count = 1'b1;
         KIND_COUNT_PR: begin
            c.do_count = 1'b1; c.match_obj = 1'b1; c.flag_only = 1'b1;
         end
         KIND_CLEAR:     c.do_clear = 1'b1;
         default: ;
      endcase
   end

   assign full = (n_ff == (PB+1)'(FIFO_DEPTH));
   assign cmd_valid = (n_ff != '0);
   assign cmd = mem_ff[rp_ff];
   assign wr = push && !full;
   assign rd = cmd_take && cmd_valid;

   always_comb begin
      wp_in = wr ? PB'(wp_ff + 1'b1) : wp_ff;
      rp_in = rd ? PB'(rp_ff + 1'b1) : rp_ff;
      n_in = n_ff + (PB+1)'(wr) - (PB+1)'(rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; n_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; n_ff <= n_in;
      end
      if (wr) mem_ff[wp_ff] <= c;
   end
endmodule
`default_nettype wire

### hw/rtl/dscq_back.sv
`timescale 1ns / 1ps
`default_nettype none
module dscq_back import dscq_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic cmd_valid,
   input  cmd_type   cmd,
   output logic      cmd_take,
   output logic      out_valid,
   output rsp_type   out_rsp,
   input  wire logic out_take
);
   logic [TIME_BITS-1:0] dl_ff [DEPTH];
   logic [CB_BITS-1:0]   cb_ff [DEPTH];
   logic [OBJ_BITS-1:0]  ob_ff [DEPTH];
   logic [CNT_BITS-1:0]  n_ff, n_in;
   state_type            st_ff, st_in;
   cmd_type              c_ff, c_in;
   logic [MC_BITS-1:0]   cnt_ff, cnt_in;
   logic                 ov_ff, ov_in;
   rsp_type              or_ff, or_in;

   logic [DEPTH-1:0] valid, hit, keep, le;
   logic [IDX_BITS-1:0] rank [DEPTH];
   logic [CNT_BITS-1:0] nkeep, pos;
   logic [DEPTH-1:0] first_hit;
   logic                 slot_free;
   logic [TIME_BITS:0]   diff;
   logic signed [TIME_BITS-1:0] tl;
   logic wr_keep, wr_ins, wr_pop;

   localparam logic signed [TIME_BITS-1:0] TMAX = {1'b0, {(TIME_BITS-1){1'b1}}};
   localparam logic signed [TIME_BITS-1:0] TMIN = {1'b1, {(TIME_BITS-1){1'b0}}};

   // per-entry match and compaction rank (prefix count of kept entries)
   always_comb begin
      nkeep = '0;
      for (int i = 0; i < DEPTH; i++) begin
         valid[i] = (CNT_BITS'(i) < n_ff);
         hit[i] = valid[i] && cb_ff[i] == c_ff.cb && (!c_ff.match_obj || ob_ff[i] == c_ff.obj);
         le[i] = valid[i] && dl_ff[i] <= c_ff.deadline;
      end
      first_hit = hit & (~hit + 1'b1);
      for (int i = 0; i < DEPTH; i++) begin
         keep[i] = valid[i] && !(c_ff.erase_one ? first_hit[i] : hit[i]);
         rank[i] = IDX_BITS'(nkeep);
         nkeep = nkeep + CNT_BITS'(keep[i]);
      end
      pos = '0;
      for (int i = 0; i < DEPTH; i++) pos = pos + CNT_BITS'(le[i]);
   end

   // time left from head entry
   always_comb begin
      diff = {1'b0, dl_ff[0]} - {1'b0, c_ff.now_time};
      if (n_ff == '0) tl = TMAX;
      else if (!diff[TIME_BITS]) tl = diff[TIME_BITS-1] ? TMAX : diff[TIME_BITS-1:0];
      else if (!diff[TIME_BITS-1] && diff[TIME_BITS-2:0] != '0) tl = TMIN;
      else tl = diff[TIME_BITS-1:0];
   end

   assign slot_free = !ov_ff || out_take;
   assign out_valid = ov_ff;
   assign out_rsp = or_ff;

   always_comb begin
      st_in = st_ff; c_in = c_ff; cnt_in = cnt_ff; n_in = n_ff;
      ov_in = ov_ff && !out_take; or_in = or_ff;
      cmd_take = 1'b0; wr_keep = 1'b0; wr_ins = 1'b0; wr_pop = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1; c_in = cmd;
               priority if (cmd.do_erase || cmd.do_count) st_in = ST_REMOVE;
               else if (cmd.do_insert) st_in = ST_INSERT;
               else if (cmd.do_invoke) st_in = ST_INVOKE;
               else if (cmd.do_clear || cmd.do_tleft) st_in = ST_INVOKE;
               else st_in = ST_INVOKE;
            end
         end
         ST_REMOVE: begin
            cnt_in = MC_BITS'($countones(hit & keep ^ hit));
            if (c_ff.do_count) cnt_in = MC_BITS'($countones(hit));
            if (c_ff.flag_only) cnt_in = MC_BITS'(cnt_in != '0);
            if (c_ff.do_erase) begin
               wr_keep = 1'b1; n_in = nkeep;
            end
            if (c_ff.do_insert) st_in = ST_INSERT;
            else if (slot_free) begin
               ov_in = 1'b1; or_in = '0; or_in.cnt = cnt_in; or_in.last = 1'b1;
               st_in = ST_IDLE;
            end else st_in = ST_INVOKE;  // wait in emit state
         end
         ST_INSERT: begin
            if (slot_free) begin
               ov_in = 1'b1; or_in = '0; or_in.last = 1'b1;
               if (n_ff == CNT_BITS'(DEPTH)) or_in.full_err = 1'b1;
               else begin wr_ins = 1'b1; n_in = n_ff + 1'b1; end
               st_in = ST_IDLE;
            end
         end
         ST_INVOKE: begin
            // also emits the single result of tleft/clear/unused/stalled erase or count
            if (slot_free) begin
               ov_in = 1'b1; or_in = '0;
               if (c_ff.do_invoke && valid[0] && dl_ff[0] <= c_ff.now_time) begin
                  or_in.fired = 1'b1; or_in.cb = cb_ff[0]; or_in.obj = ob_ff[0];
                  wr_pop = 1'b1; n_in = n_ff - 1'b1;
               end else begin
                  or_in.last = 1'b1;
                  if (c_ff.do_invoke || c_ff.do_tleft) or_in.tleft = tl;
                  if (c_ff.do_erase || c_ff.do_count) or_in.cnt = cnt_ff;
                  if (c_ff.do_clear) n_in = '0;
                  st_in = ST_IDLE;
               end
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; n_ff <= '0; ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in; n_ff <= n_in; ov_ff <= ov_in;
      end
      c_ff <= c_in; cnt_ff <= cnt_in; or_ff <= or_in;
      for (int i = 0; i < DEPTH; i++) begin
         if (wr_keep) begin
            for (int j = i; j < DEPTH; j++) begin
               if (keep[j] && rank[j] == IDX_BITS'(i)) begin
                  dl_ff[i] <= dl_ff[j]; cb_ff[i] <= cb_ff[j]; ob_ff[i] <= ob_ff[j];
               end
            end
         end else if (wr_pop) begin
            if (i + 1 < DEPTH) begin
               dl_ff[i] <= dl_ff[i+1]; cb_ff[i] <= cb_ff[i+1]; ob_ff[i] <= ob_ff[i+1];
            end
         end else if (wr_ins) begin
            if (CNT_BITS'(i) == pos) begin
               dl_ff[i] <= c_ff.deadline; cb_ff[i] <= c_ff.cb; ob_ff[i] <= c_ff.obj;
            end else if (CNT_BITS'(i) > pos && i > 0) begin
               dl_ff[i] <= dl_ff[i-1]; cb_ff[i] <= cb_ff[i-1]; ob_ff[i] <= ob_ff[i-1];
            end
         end
      end
   end

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      n_ff <= CNT_BITS'(DEPTH)) else $error("entry count over depth");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ov_ff && !out_take |=> ov_ff && $stable(or_ff)) else $error("result overwritten");
   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      wr_pop |-> n_ff != '0) else $error("pop of empty queue");
`endif
endmodule
`default_nettype wire

### hw/rtl/deadline_sorted_callback_queue_core.sv
// Deadline-sorted callback timer queue, 16 entries.
// Request channel: drive req_kind/req_callback_id/req_object_id/req_deadline/
// req_now_time and raise push; a beat is taken on a clock edge with push high
// and full low. A two-deep command queue sits in front of the executor.
// Response channel: while empty is low the rsp_* ports show the oldest result;
// pop with empty low takes it. Each request yields one result with rsp_last set,
// except invoke, which first gives one fired beat per expired entry.
// Each command is taken from the command queue and then executed; update runs
// an erase pass, then an insert pass, and invoke emits its fired beats one per
// expired entry before its final result.
// The executor runs one command at a time on a register cell array with a
// single result register.
// When the receiver stalls, the result register holds and the executor waits;
// requests keep filling the command queue until full rises.
// Reset (synchronous, active high) empties the queue of entries and both buffers.
`timescale 1ns / 1ps
`default_nettype none
module deadline_sorted_callback_queue_core import dscq_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   output logic                      full,
   input  wire logic [3:0]           req_kind,
   input  wire logic [CB_BITS-1:0]   req_callback_id,
   input  wire logic [OBJ_BITS-1:0]  req_object_id,
   input  wire logic [TIME_BITS-1:0] req_deadline,
   input  wire logic [TIME_BITS-1:0] req_now_time,
   output logic                      empty,
   input  wire logic                 pop,
   output logic                      rsp_fired,
   output logic [CB_BITS-1:0]        rsp_fired_callback,
   output logic [OBJ_BITS-1:0]       rsp_fired_object,
   output logic [MC_BITS-1:0]        rsp_match_count,
   output logic signed [TIME_BITS-1:0] rsp_time_left,
   output logic                      rsp_full_error,
   output logic                      rsp_last
);
   cmd_type cmd;
   rsp_type r;
   logic    cmd_valid, cmd_take, out_valid;

   dscq_front u_front (
      .clock, .reset, .push, .full,
      .kind(req_kind), .cb(req_callback_id), .obj(req_object_id),
      .deadline(req_deadline), .now_time(req_now_time),
      .cmd_valid, .cmd, .cmd_take
   );

   dscq_back u_back (
      .clock, .reset, .cmd_valid, .cmd, .cmd_take,
      .out_valid, .out_rsp(r), .out_take(pop)
   );

   assign empty = !out_valid;
   assign rsp_fired = r.fired;
   assign rsp_fired_callback = r.cb;
   assign rsp_fired_object = r.obj;
   assign rsp_match_count = r.cnt;
   assign rsp_time_left = r.tleft;
   assign rsp_full_error = r.full_err;
   assign rsp_last = r.last;
endmodule
`default_nettype wire
